// ===== hw/rtl/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and codes for the LRU replacement block with reuse counts.
// ----------------------------------------------------------------------------
package lrc_pkg;

  // Request codes
  localparam logic REQ_VICTIM = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Width of the request and result way fields
  localparam int WAY_FIELD_W = 4;
  // Width of the set_index field
  localparam int SET_FIELD_W = 11;

  // Control state of the top level
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } lrc_state_t;

  // Held request, passed to the update logic
  typedef struct packed {
    logic                   req_type;
    logic [WAY_FIELD_W-1:0] way;
    logic                   hit;
  } lrc_req_t;

endpackage

// ===== hw/rtl/lrc_ram.sv =====
// ----------------------------------------------------------------------------
// lrc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/lrc_set_reduce.sv =====
// ----------------------------------------------------------------------------
// lrc_set_reduce
// Folds set_index into the range of the set memory (index modulo NUM_SETS).
// Quotient by reciprocal multiply at load, remainder and correction after.
// ----------------------------------------------------------------------------
module lrc_set_reduce
  import lrc_pkg::*;
#(
  parameter int NUM_SETS = 2048,
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [SET_FIELD_W-1:0] set_index,
  output logic [SET_W-1:0]       set_addr
);

  localparam int K       = 24;
  localparam int RECIP_W = K + 1;
  localparam int PROD_W  = SET_FIELD_W + RECIP_W;
  localparam int REM_W   = SET_FIELD_W + 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << K) / NUM_SETS);
  localparam logic [REM_W-1:0]   SETS  = REM_W'(NUM_SETS);

  logic [SET_FIELD_W-1:0] idx;
  logic [SET_FIELD_W-1:0] quo;
  logic [PROD_W-1:0]      prod;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_fix;

  // Quotient estimate, at most one short of the true quotient
  assign prod = PROD_W'(set_index) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= set_index;
      quo <= prod[K +: SET_FIELD_W];
    end
  end

  // Remainder, with one corrective subtract
  always_comb begin
    rem     = REM_W'(idx) - (REM_W'(quo) * SETS);
    rem_fix = (rem >= SETS) ? (rem - SETS) : rem;
  end

  assign set_addr = rem_fix[SET_W-1:0];

endmodule

// ===== hw/rtl/lrc_update.sv =====
// ----------------------------------------------------------------------------
// lrc_update
// Per-set modify logic: picks the victim and computes the new rank and
// reuse-count words for an update.
// ----------------------------------------------------------------------------
module lrc_update
  import lrc_pkg::*;
#(
  parameter int NUM_WAYS    = 16,
  parameter int COUNT_WIDTH = 8,
  localparam int RANK_W = $clog2(NUM_WAYS)
) (
  input  lrc_req_t                          req,
  input  logic [NUM_WAYS*RANK_W-1:0]        rank_word,
  input  logic [NUM_WAYS*COUNT_WIDTH-1:0]   cnt_word,
  output logic                              way_ok,
  output logic [WAY_FIELD_W-1:0]            victim,
  output logic [NUM_WAYS*RANK_W-1:0]        rank_new,
  output logic [NUM_WAYS*COUNT_WIDTH-1:0]   cnt_new
);

  localparam logic [RANK_W-1:0]      RANK_LAST = RANK_W'(NUM_WAYS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;

  logic [NUM_WAYS-1:0] touch;
  logic [RANK_W-1:0]   own;

  // Decode the touched way; ways beyond NUM_WAYS touch nothing
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      touch[i] = ({2'b00, req.way} == 6'(i));
    end
  end

  assign way_ok = |touch;

  // Current rank of the touched way
  always_comb begin
    own = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (touch[i]) begin
        own = rank_word[i*RANK_W +: RANK_W];
      end
    end
  end

  // Victim: the least recently used way. Ranks are a permutation, so exactly
  // one way holds the last rank; the lowest way wins regardless.
  always_comb begin
    victim = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (rank_word[i*RANK_W +: RANK_W] == RANK_LAST) begin
        victim = WAY_FIELD_W'(i);
      end
    end
  end

  // New ranks: touched way to the front, younger ways age by one
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (touch[i]) begin
        rank_new[i*RANK_W +: RANK_W] = '0;
      end else if (rank_word[i*RANK_W +: RANK_W] < own) begin
        rank_new[i*RANK_W +: RANK_W] = rank_word[i*RANK_W +: RANK_W] + RANK_W'(1);
      end else begin
        rank_new[i*RANK_W +: RANK_W] = rank_word[i*RANK_W +: RANK_W];
      end
    end
  end

  // New counts: saturating increment on a hit, cleared on a fill
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!touch[i]) begin
        cnt_new[i*COUNT_WIDTH +: COUNT_WIDTH] = cnt_word[i*COUNT_WIDTH +: COUNT_WIDTH];
      end else if (!req.hit) begin
        cnt_new[i*COUNT_WIDTH +: COUNT_WIDTH] = '0;
      end else if (cnt_word[i*COUNT_WIDTH +: COUNT_WIDTH] == CNT_MAX) begin
        cnt_new[i*COUNT_WIDTH +: COUNT_WIDTH] = CNT_MAX;
      end else begin
        cnt_new[i*COUNT_WIDTH +: COUNT_WIDTH] =
          cnt_word[i*COUNT_WIDTH +: COUNT_WIDTH] + COUNT_WIDTH'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lru_replacement_with_reuse_count.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_with_reuse_count
// True-LRU replacement state for a set-associative cache, with a saturating
// reuse count per way. One memory word per set holds all ranks, another all
// counts; each update reads, modifies and writes back its set's words.
// ----------------------------------------------------------------------------
//  channel  valid      stall      payload
//  -------  ---------  ---------  ---------------------------------
//  request  req_valid  req_stall  req_type, set_index, way, hit
//  result   res_valid  res_stall  victim_way (victim queries only)
//
//  Every request passes three steps: accept, set memory read, modify/write back.
//  The registered read of the set memories makes the read a step of its own.
//  After reset a clearing pass writes each of the NUM_SETS sets (2048 by
//  default), one a cycle, with req_stall high.
//  A victim query waits in the modify step while the result register is
//  full and stalled; the next word is accepted while a result waits.
// ----------------------------------------------------------------------------
module lru_replacement_with_reuse_count
  import lrc_pkg::*;
#(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   req_type,
  input  logic [SET_FIELD_W-1:0] set_index,
  input  logic [WAY_FIELD_W-1:0] way,
  input  logic                   hit,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [WAY_FIELD_W-1:0] victim_way
);

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RANK_W    = $clog2(NUM_WAYS);
  localparam int RANK_BITS = NUM_WAYS * RANK_W;
  localparam int CNT_BITS  = NUM_WAYS * COUNT_WIDTH;
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

  lrc_state_t state, state_next;
  lrc_req_t   req;

  logic [SET_W-1:0]     clr_addr;
  logic [SET_W-1:0]     set_addr;
  logic [SET_W-1:0]     set_hold;
  logic [SET_W-1:0]     rd_addr;
  logic [SET_W-1:0]     wr_addr;
  logic                 wr_en;
  logic                 accept;
  logic                 load_res;
  logic                 res_free;
  logic [RANK_BITS-1:0] rank_rd;
  logic [RANK_BITS-1:0] rank_wr;
  logic [RANK_BITS-1:0] rank_new;
  logic [RANK_BITS-1:0] rank_init;
  logic [CNT_BITS-1:0]  cnt_rd;
  logic [CNT_BITS-1:0]  cnt_wr;
  logic [CNT_BITS-1:0]  cnt_new;
  logic                 way_ok;
  logic [WAY_FIELD_W-1:0] victim;

  assign accept   = req_valid && !req_stall;
  assign res_free = !res_valid || !res_stall;

  // Reset word of a set: rank equals way number
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      rank_init[i*RANK_W +: RANK_W] = RANK_W'(i);
    end
  end

  // Set index reduction
  lrc_set_reduce #(
    .NUM_SETS (NUM_SETS)
  ) u_reduce (
    .clk       (clk),
    .load      (accept),
    .set_index (set_index),
    .set_addr  (set_addr)
  );

  // Rank and count memories
  lrc_ram #(
    .WIDTH (RANK_BITS),
    .DEPTH (NUM_SETS)
  ) u_rank_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (rank_wr),
    .rd_addr (rd_addr),
    .rd_data (rank_rd)
  );

  lrc_ram #(
    .WIDTH (CNT_BITS),
    .DEPTH (NUM_SETS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cnt_wr),
    .rd_addr (rd_addr),
    .rd_data (cnt_rd)
  );

  // Modify logic
  lrc_update #(
    .NUM_WAYS    (NUM_WAYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .req       (req),
    .rank_word (rank_rd),
    .cnt_word  (cnt_rd),
    .way_ok    (way_ok),
    .victim    (victim),
    .rank_new  (rank_new),
    .cnt_new   (cnt_new)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == SET_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (req.req_type == REQ_UPDATE || res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    req_stall = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = set_hold;
    rank_wr   = rank_new;
    cnt_wr    = cnt_new;
    rd_addr   = set_hold;
    load_res  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        rank_wr = rank_init;
        cnt_wr  = '0;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_READ: begin
        rd_addr = set_addr;
      end
      ST_MODIFY: begin
        if (req.req_type == REQ_UPDATE) begin
          wr_en = way_ok;
        end else begin
          load_res = res_free;
        end
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + SET_W'(1);
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req.req_type <= req_type;
      req.way      <= way;
      req.hit      <= hit;
    end
    if (state == ST_READ) set_hold <= set_addr;
    if (load_res) victim_way <= victim;
  end

endmodule
